FILE: design/fan_speed_regulator_top_assert.svh
// Assertion macros for the fan speed regulator.
// Included by fan_speed_regulator_top; depends on nothing else.
`ifndef FAN_SPEED_REGULATOR_TOP_ASSERT_SVH
`define FAN_SPEED_REGULATOR_TOP_ASSERT_SVH

// condition must hold at every edge out of reset
`define FSR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent must hold at the clock edge after the antecedent
`define FSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/fsr_pkg.sv
// Types, constants and scaling helpers for the fan speed regulator.
// No dependencies; used by fan_speed_regulator_top.
package fsr_pkg;

   localparam int TEMP_W  = 8;
   localparam int SPEED_W = 6;
   localparam int SCALED_W = 13;   // 255 * 20 = 5100
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   // band half width in 1/20 degC (0.75 degC)
   localparam logic [SCALED_W:0] BAND_HALF = 14'd15;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_TEMP   = 2'd0,
      CSR_MIN_FAN_SPEED = 2'd1,
      CSR_REV16_SCALING = 2'd2,
      CSR_START_SPEED   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TEMP_W-1:0]  cpu_reading;
      logic [TEMP_W-1:0]  gpu_reading;
      logic [SPEED_W-1:0] fan_reported;
   } req_word_type;

   typedef struct packed {
      logic               write_fan;
      logic [SPEED_W-1:0] fan_speed;
      logic               hot_sensor;
   } rsp_word_type;

   // raw degC to 1/20 degC: x*16 + x*4
   function automatic logic [SCALED_W-1:0] scale_by_20(input logic [TEMP_W-1:0] raw);
      logic [SCALED_W-1:0] ext;
      ext = SCALED_W'(raw);
      return (ext << 4) + (ext << 2);
   endfunction

   // GPU scaling: x*16 on rev16 boards, x*20 otherwise
   function automatic logic [SCALED_W-1:0] scale_gpu(input logic [TEMP_W-1:0] raw,
                                                     input logic rev16);
      logic [SCALED_W-1:0] ext;
      ext = SCALED_W'(raw);
      return rev16 ? (ext << 4) : scale_by_20(raw);
   endfunction

endpackage

FILE: design/fan_speed_regulator_top.sv
// Fan speed regulator: one sensor word in, one fan command word out.
// Depends on fsr_pkg and fan_speed_regulator_top_assert.svh.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+---------------------------
//   req_     | in        | req_valid/req_stall | cpu, gpu, reported fan speed
//   rsp_     | out       | rsp_valid/rsp_stall | write_fan, fan_speed, sensor
//   csr_     | in        | csr_we              | csr_index, csr_wdata
//
// Two register stages: input register, then result register. A word accepted
// into the input register passes through the combinational regulation logic
// into the result register, where rsp_valid rises; one word per cycle sustained
// while rsp_stall is low.
// Reset is synchronous and loads the register defaults and the seed speed.
// A stall on rsp_ holds the result register; req_stall rises only while the
// input register is full and cannot move on.
module fan_speed_regulator_top #(
   parameter int MAX_SPEED  = 50,
   parameter int HOLD_TICKS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fsr_pkg::req_word_type            req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fsr_pkg::rsp_word_type            rsp_word,
   input  logic                             csr_we,
   input  logic [fsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fsr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fsr_pkg::*;

`include "fan_speed_regulator_top_assert.svh"

   localparam logic [SPEED_W-1:0]   MAX_SPD  = SPEED_W'(MAX_SPEED);
   localparam logic signed [7:0]    HOLD_CNT = 8'(HOLD_TICKS);
   localparam logic [SPEED_W-1:0]   SEED_RST = (10 > MAX_SPEED) ? MAX_SPD : 6'd10;

   // configuration
   logic [TEMP_W-1:0]   target_temp_ff;
   logic [SPEED_W-1:0]  min_fan_speed_ff;
   logic                rev16_ff;

   // regulation state
   logic [TEMP_W-1:0]   prev_cpu_ff, prev_cpu_in;
   logic [TEMP_W-1:0]   prev_gpu_ff, prev_gpu_in;
   logic                have_prev_ff;
   logic [SPEED_W-1:0]  speed_ff, speed_in;
   logic signed [7:0]   hot_ticks_ff, hot_ticks_in;
   logic signed [7:0]   cold_ticks_ff, cold_ticks_in;

   // pipeline
   logic                s1_valid_ff;
   req_word_type        s1_word_ff;
   logic                rsp_valid_ff;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                out_free;
   logic                s1_adv;
   logic                req_acc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // regulation datapath
   logic [SCALED_W-1:0]  cpu_t, gpu_t, cur_t, old_t;
   logic [SCALED_W:0]    center, t_ext;
   logic                 use_gpu, below, above, rising, falling, flat;
   logic [SPEED_W-1:0]   eff_min;
   logic signed [7:0]    sp_step, cnt_step;
   logic                 step_up, step_dn;

   always_comb begin
      cpu_t   = scale_by_20(s1_word_ff.cpu_reading);
      gpu_t   = scale_gpu(s1_word_ff.gpu_reading, rev16_ff);
      use_gpu = cpu_t < gpu_t;
      cur_t   = use_gpu ? gpu_t : cpu_t;
      old_t   = use_gpu ? scale_gpu(prev_gpu_ff, rev16_ff) : scale_by_20(prev_cpu_ff);
      center  = {1'b0, scale_by_20(target_temp_ff)};
      t_ext   = {1'b0, cur_t};
      below   = (t_ext + BAND_HALF) < center;
      above   = t_ext > (center + BAND_HALF);
      rising  = cur_t > old_t;
      falling = cur_t < old_t;
      flat    = !rising && !falling;

      // effective minimum: 0 acts as 1, above max acts as max
      if (min_fan_speed_ff == '0) begin
         eff_min = SPEED_W'(1);
      end else if (min_fan_speed_ff > MAX_SPD) begin
         eff_min = MAX_SPD;
      end else begin
         eff_min = min_fan_speed_ff;
      end

      hot_ticks_in  = hot_ticks_ff;
      cold_ticks_in = cold_ticks_ff;
      step_up       = 1'b0;
      step_dn       = 1'b0;
      cnt_step      = '0;

      if (below) begin
         // cold side: count flat ticks, back off on rising
         if (flat) begin
            cnt_step = (cold_ticks_ff == 8'sd127) ? cold_ticks_ff : cold_ticks_ff + 8'sd1;
         end else if (rising) begin
            cnt_step = (cold_ticks_ff == -8'sd128) ? cold_ticks_ff : cold_ticks_ff - 8'sd1;
         end else begin
            cnt_step = cold_ticks_ff;
         end
         if (falling || cnt_step == HOLD_CNT) begin
            step_dn       = 1'b1;
            cold_ticks_in = '0;
         end else begin
            cold_ticks_in = cnt_step;
         end
      end else if (above) begin
         // hot side mirrors the cold side
         if (flat) begin
            cnt_step = (hot_ticks_ff == 8'sd127) ? hot_ticks_ff : hot_ticks_ff + 8'sd1;
         end else if (falling) begin
            cnt_step = (hot_ticks_ff == -8'sd128) ? hot_ticks_ff : hot_ticks_ff - 8'sd1;
         end else begin
            cnt_step = hot_ticks_ff;
         end
         if (rising || cnt_step == HOLD_CNT) begin
            step_up      = 1'b1;
            hot_ticks_in = '0;
         end else begin
            hot_ticks_in = cnt_step;
         end
      end else begin
         // in band: follow the trend
         hot_ticks_in  = '0;
         cold_ticks_in = '0;
         step_up       = rising;
         step_dn       = falling;
      end

      sp_step = $signed({2'b00, speed_ff});
      if (step_up) begin
         sp_step = sp_step + 8'sd1;
      end else if (step_dn) begin
         sp_step = sp_step - 8'sd1;
      end

      if (sp_step < $signed({2'b00, eff_min})) begin
         speed_in = eff_min;
      end else if (sp_step > $signed({2'b00, MAX_SPD})) begin
         speed_in = MAX_SPD;
      end else begin
         speed_in = sp_step[SPEED_W-1:0];
      end

      prev_cpu_in = s1_word_ff.cpu_reading;
      prev_gpu_in = s1_word_ff.gpu_reading;

      // first tick only stores samples
      rsp_word_in.hot_sensor = use_gpu;
      if (have_prev_ff) begin
         rsp_word_in.fan_speed = speed_in;
         rsp_word_in.write_fan = speed_in != s1_word_ff.fan_reported;
      end else begin
         rsp_word_in.fan_speed = speed_ff;
         rsp_word_in.write_fan = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_acc) begin
         s1_word_ff <= req_word;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_temp_ff   <= 8'd55;
         min_fan_speed_ff <= SPEED_W'(1);
         rev16_ff         <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_TEMP:   target_temp_ff   <= csr_wdata;
            CSR_MIN_FAN_SPEED: min_fan_speed_ff <= csr_wdata[SPEED_W-1:0];
            CSR_REV16_SCALING: rev16_ff         <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // regulation state; a start speed write reseeds the speed
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cpu_ff   <= '0;
         prev_gpu_ff   <= '0;
         have_prev_ff  <= 1'b0;
         speed_ff      <= SEED_RST;
         hot_ticks_ff  <= '0;
         cold_ticks_ff <= '0;
      end else if (csr_we && csr_index == CSR_START_SPEED) begin
         speed_ff <= (csr_wdata[SPEED_W-1:0] > MAX_SPD) ? MAX_SPD : csr_wdata[SPEED_W-1:0];
      end else if (s1_adv) begin
         prev_cpu_ff  <= prev_cpu_in;
         prev_gpu_ff  <= prev_gpu_in;
         have_prev_ff <= 1'b1;
         if (have_prev_ff) begin
            speed_ff      <= speed_in;
            hot_ticks_ff  <= hot_ticks_in;
            cold_ticks_ff <= cold_ticks_in;
         end
      end
   end

   // checks
   `FSR_ASSERT_ALWAYS(a_speed_max, clock, reset, speed_ff <= MAX_SPD, "speed above maximum")
   `FSR_ASSERT_ALWAYS(a_cnt_hold, clock, reset,
      (hot_ticks_ff != HOLD_CNT) && (cold_ticks_ff != HOLD_CNT), "tick counter left at hold")
   `FSR_ASSERT_NEXT(a_first_nowrite, clock, reset, s1_adv && !have_prev_ff,
      !rsp_word_ff.write_fan, "write requested on first tick")
   `FSR_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && rsp_valid_ff && rsp_stall,
      s1_valid_ff, "input word dropped while output stalled")

endmodule
